### rtl/hed_pkg.sv
// Shared types, character codes and name table for the HTML entity decoder.
package hed_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 16;
  localparam int unsigned NUM_NAMES      = 8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] VAL_SAT  = 8'd128;

  // name text, byte 0 in the low lane
  typedef logic [3:0][7:0] name_text_t;

  localparam name_text_t NAME_TEXT [NUM_NAMES] = '{
    {8'h00, "pma"}, {16'h0000, "tl"}, {16'h0000, "tg"}, "touq",
    "sopa", "psbn", "ypoc", {8'h00, "ger"}
  };
  localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3
  };
  localparam logic [7:0] NAME_CH [NUM_NAMES] = '{
    8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20, 8'h63, 8'h72
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PROC,
    ST_LFAIL
  } ctl_state_e;

  typedef enum logic [2:0] {
    BK_FIRST,
    BK_NAME,
    BK_NUMX,
    BK_DEC,
    BK_HEX
  } body_kind_e;

  typedef enum logic [2:0] {
    NP_WS,
    NP_SIGN,
    NP_ZERO,
    NP_XPEND,
    NP_DIGIT,
    NP_STOP
  } num_phase_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic proc;
    logic fail;
    logic flush;
  } hed_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic in_entity;
    logic last;
    logic move_ok;
  } hed_status_t;

  localparam logic [4:0] DIGIT_NONE = 5'd31;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    return d;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

### rtl/hed_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hed_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hed_ctrl.sv
// Controller state machine: input acceptance, byte reads, replay and flush sequencing.
module hed_ctrl
  import hed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hed_status_t status_i,
  output hed_cmd_t    cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!status_i.q_empty) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_PROC;
        end else if (status_i.last && status_i.in_entity) begin
          state_d = ST_LFAIL;
        end else if (status_i.move_ok) begin
          // beat done: push the held byte out, tagged with last
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_PROC: begin
        if (status_i.move_ok) begin
          cmd_o.proc = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_LFAIL: begin
        if (status_i.move_ok) begin
          cmd_o.fail = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/hed_datapath.sv
// Datapath: byte queue RAM, pointers, incremental name and number parser, output stages.
module hed_datapath
  import hed_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hed_cmd_t    cmd_i,
  input  in_item_t    in_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output out_item_t   out_data_o,
  output hed_status_t status_o
);

  localparam int unsigned AW    = $clog2(WINDOW_LEN);
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned PW    = AW + 1;
  localparam int unsigned WCW   = $clog2(WINDOW_LEN + 1);

  // stream pointers carry one wrap bit; window is [wstart, head)
  logic [PW-1:0]  tail_q, tail_d, head_q, head_d, wstart_q, wstart_d;
  logic           ent_q, ent_d, last_q, last_d;
  logic [WCW-1:0] wcount_q, wcount_d, eff_q, eff_d;
  body_kind_e     kind_q, kind_d;
  logic           zs_q, zs_d, neg_q, neg_d;
  logic [NUM_NAMES-1:0] cand_q, cand_d;
  num_phase_e     phase_q, phase_d;
  logic [7:0]     val_q, val_d;
  logic           hold_valid_q, hold_valid_d, out_valid_q, out_valid_d;
  logic [7:0]     hold_byte_q, hold_byte_d;
  out_item_t      out_q, out_d;

  logic [7:0]     b;
  logic [WCW-1:0] wcount_n;
  logic           move_ok, emit_en, rewind;
  logic [7:0]     emit_byte;
  logic           dec_ok;
  logic [7:0]     dec_ch;
  logic           name_go, num_go, num_hex, isdig;
  logic [4:0]     dig;
  logic [11:0]    acc_w;
  logic [7:0]     acc;

  hed_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept),
    .waddr_i(tail_q[AW-1:0]),
    .wdata_i(in_data_i.in_byte),
    .re_i   (cmd_i.rd),
    .raddr_i(head_q[AW-1:0]),
    .rdata_o(b)
  );

  assign move_ok  = !hold_valid_q || !out_valid_q || out_ready_i;
  assign wcount_n = wcount_q + WCW'(1);
  assign num_hex  = (kind_q == BK_HEX);

  assign status_o.q_empty   = (head_q == tail_q);
  assign status_o.in_entity = ent_q;
  assign status_o.last      = last_q;
  assign status_o.move_ok   = move_ok;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // decode of the body at ';'
  always_comb begin
    dec_ok = 1'b0;
    dec_ch = val_q;
    case (kind_q)
      BK_NAME: begin
        for (int i = 0; i < NUM_NAMES; i++) begin
          if (cand_q[i] && eff_q == WCW'(NAME_LEN[i])) begin
            dec_ok = 1'b1;
            dec_ch = NAME_CH[i];
          end
        end
      end
      BK_DEC, BK_HEX: begin
        dec_ok = !neg_q && (val_q != 8'd0) && !val_q[7];
      end
      default: dec_ok = 1'b0;
    endcase
  end

  // digit accumulate, saturating at 128
  always_comb begin
    dig   = digit_of(b);
    isdig = num_hex ? (dig < 5'd16) : (dig < 5'd10);
    if (num_hex) begin
      acc_w = {val_q, 4'b0000} + 12'(dig);
    end else begin
      acc_w = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + 12'(dig);
    end
    acc = (acc_w > 12'(VAL_SAT)) ? VAL_SAT : acc_w[7:0];
  end

  always_comb begin
    tail_d       = tail_q;
    head_d       = head_q;
    wstart_d     = wstart_q;
    ent_d        = ent_q;
    last_d       = last_q;
    wcount_d     = wcount_q;
    eff_d        = eff_q;
    kind_d       = kind_q;
    zs_d         = zs_q;
    neg_d        = neg_q;
    cand_d       = cand_q;
    phase_d      = phase_q;
    val_d        = val_q;
    hold_valid_d = hold_valid_q;
    hold_byte_d  = hold_byte_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    emit_en      = 1'b0;
    emit_byte    = b;
    rewind       = 1'b0;
    name_go      = 1'b0;
    num_go       = 1'b0;

    if (cmd_i.accept) begin
      tail_d = tail_q + PW'(1);
      last_d = in_data_i.in_last;
    end

    if (cmd_i.proc) begin
      head_d = head_q + PW'(1);
      if (!ent_q) begin
        if (b == CH_AMP) begin
          ent_d    = 1'b1;
          wstart_d = head_q + PW'(1);
          wcount_d = '0;
          kind_d   = BK_FIRST;
          eff_d    = '0;
          zs_d     = 1'b0;
          cand_d   = '1;
          phase_d  = NP_WS;
          neg_d    = 1'b0;
          val_d    = 8'd0;
        end else begin
          emit_en = 1'b1;
        end
      end else if (b == CH_SEMI) begin
        if (dec_ok) begin
          emit_en   = 1'b1;
          emit_byte = dec_ch;
          ent_d     = 1'b0;
        end else begin
          rewind = 1'b1;
        end
      end else if (b == CH_SPACE || wcount_n >= WCW'(WINDOW_LEN)) begin
        rewind = 1'b1;
      end else begin
        wcount_d = wcount_n;
        case (kind_q)
          BK_FIRST: begin
            if (b == CH_HASH) begin
              kind_d = BK_NUMX;
            end else begin
              kind_d  = BK_NAME;
              name_go = 1'b1;
            end
          end
          BK_NAME: name_go = 1'b1;
          BK_NUMX: begin
            if ((b | CH_CASE) == CH_LX) begin
              kind_d = BK_HEX;
            end else begin
              kind_d = BK_DEC;
              num_go = 1'b1;
            end
          end
          BK_DEC, BK_HEX: num_go = 1'b1;
          default: kind_d = BK_NAME;
        endcase
      end
    end

    // name match: body counts only up to the first NUL
    if (name_go && !zs_q) begin
      if (b == CH_NUL) begin
        zs_d = 1'b1;
      end else begin
        for (int i = 0; i < NUM_NAMES; i++) begin
          cand_d[i] = cand_q[i] && (eff_q < WCW'(NAME_LEN[i])) &&
                      (NAME_TEXT[i][eff_q[1:0]] == b);
        end
        eff_d = eff_q + WCW'(1);
      end
    end

    // strtol-style number scan; NUL is a non-digit and stops it
    if (num_go) begin
      case (phase_q)
        NP_WS, NP_SIGN: begin
          if (phase_q == NP_WS && is_ws(b)) begin
            phase_d = NP_WS;
          end else if (phase_q == NP_WS && b == CH_PLUS) begin
            phase_d = NP_SIGN;
          end else if (phase_q == NP_WS && b == CH_MINUS) begin
            phase_d = NP_SIGN;
            neg_d   = 1'b1;
          end else if (isdig) begin
            val_d   = acc;
            phase_d = (num_hex && b == CH_ZERO) ? NP_ZERO : NP_DIGIT;
          end else begin
            phase_d = NP_STOP;
          end
        end
        NP_ZERO: begin
          if (num_hex && (b | CH_CASE) == CH_LX) begin
            phase_d = NP_XPEND;
          end else if (isdig) begin
            val_d   = acc;
            phase_d = NP_DIGIT;
          end else begin
            phase_d = NP_STOP;
          end
        end
        NP_XPEND, NP_DIGIT: begin
          if (isdig) begin
            val_d   = acc;
            phase_d = NP_DIGIT;
          end else begin
            phase_d = NP_STOP;
          end
        end
        default: phase_d = NP_STOP;
      endcase
    end

    if (cmd_i.fail) begin
      rewind = 1'b1;
    end

    // failed window: emit '&' and replay the held bytes
    if (rewind) begin
      emit_en   = 1'b1;
      emit_byte = CH_AMP;
      head_d    = wstart_q;
      ent_d     = 1'b0;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // one-deep hold so the final beat of a run can get its last flag
    if (emit_en) begin
      if (hold_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = '{out_byte: hold_byte_q, out_last: 1'b0};
      end
      hold_valid_d = 1'b1;
      hold_byte_d  = emit_byte;
    end

    if (cmd_i.flush && hold_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = '{out_byte: hold_byte_q, out_last: last_q};
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q       <= '0;
      head_q       <= '0;
      wstart_q     <= '0;
      ent_q        <= 1'b0;
      last_q       <= 1'b0;
      wcount_q     <= '0;
      kind_q       <= BK_FIRST;
      phase_q      <= NP_WS;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      tail_q       <= tail_d;
      head_q       <= head_d;
      wstart_q     <= wstart_d;
      ent_q        <= ent_d;
      last_q       <= last_d;
      wcount_q     <= wcount_d;
      kind_q       <= kind_d;
      phase_q      <= phase_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eff_q       <= eff_d;
    zs_q        <= zs_d;
    neg_q       <= neg_d;
    cand_q      <= cand_d;
    val_q       <= val_d;
    hold_byte_q <= hold_byte_d;
    out_q       <= out_d;
  end

endmodule

### rtl/html_entity_decoder_core.sv
// Top level of the streaming HTML character reference decoder.
// Text bytes go in one beat at a time and decoded bytes come out; an '&' opens a
// window of up to WINDOW_LEN bytes that is decoded at ';' as a named, decimal or hex
// reference, and on failure '&' is emitted and the held bytes are replayed. One input
// beat is handled at a time: it is accepted, then each byte is scanned (a queue RAM
// read with registered data, then the parser step), and then the beat is closed. A
// failed window replays its held bytes through the same scan, and a window left open
// at the end of the text is failed and replayed the same way. Output stalls hold the
// scan in place. The last output beat of a run carries out_last.
module html_entity_decoder_core
  import hed_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  hed_cmd_t    cmd;
  hed_status_t status;

  hed_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  hed_datapath #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .status_o   (status)
  );

endmodule

### rtl/hed_checker.sv
// Port-level assertions for the decoder core, bound onto the top level.
module hed_checker
  import hed_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a beat");

  a_busy_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 !in_ready_o)
    else $error("input ready before the byte was scanned");

endmodule

bind html_entity_decoder_core hed_checker u_hed_checker (.*);
